[sv/tcphft_pkg.sv]
// Shared types, constants and helpers of the TCP handshake flow table.
package tcphft_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int TIME_W  = 48;
    localparam int KEY_W   = 96;
    localparam int STAMP_W = TIME_W + 1;

    localparam logic [3:0] IPV4_VERSION = 4'd4;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_ACK_BIT = 4;

    localparam logic [1:0] ST_IGNORED = 2'd0;
    localparam logic [1:0] ST_MATCHED = 2'd1;
    localparam logic [1:0] ST_CREATED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] KIND_SYN    = 2'd0;
    localparam logic [1:0] KIND_SYNACK = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    typedef struct packed {
        logic [3:0]        ip_version;
        logic [31:0]       src_addr;
        logic [31:0]       dst_addr;
        logic [15:0]       sport;
        logic [15:0]       dport;
        logic [7:0]        tcp_flags;
        logic [TIME_W-1:0] time_us;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic [9:0]               entry_index;
        logic [1:0]               packet_kind;
        logic                     just_completed;
        logic signed [TIME_W-1:0] duration_us;
        logic [10:0]              entries_used;
        logic [10:0]              completed_entries;
    } t_out_word;

    function automatic logic [1:0] classify(input logic [7:0] flags);
        logic syn;
        logic ack;
        logic [1:0] kind;
        syn = flags[FLAG_SYN_BIT];
        ack = flags[FLAG_ACK_BIT];
        if (syn && !ack) begin
            kind = KIND_SYN;
        end else if (syn && ack) begin
            kind = KIND_SYNACK;
        end else if (ack) begin
            kind = KIND_ACK;
        end else begin
            kind = KIND_OTHER;
        end
        return kind;
    endfunction

endpackage

[sv/tcphft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcphft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/tcp_handshake_flow_table_unit.sv]
// Top level of the TCP handshake flow table: sequencer, key scan and entry update.
// Sequence: a non-IPv4 word strobes its result in the cycle after acceptance; an IPv4 word
// scans the used entries one per cycle, so a hit at entry k strobes after SCAN, LOAD and
// UPDATE, and a new or full lookup once all N entries in use are scanned.
// Throughput: busy is low again in the strobe cycle, so the next word can be accepted at
// the edge that takes the result; the receiver never stalls the block.
// Reset clears the counts and the sequencer only; the memories need no clearing pass.
module tcp_handshake_flow_table_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  tcphft_pkg::t_in_word i_item,
    output logic                 o_busy,
    output logic                 o_done,
    output tcphft_pkg::t_out_word o_result
);

    // Sequencer states. SCAN walks the key memory; LOAD waits for the stamp
    // memory read of the matched entry; UPDATE applies the packet to it.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_LOAD   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0]                       r_state, n_state;
    tcphft_pkg::t_in_word             r_in, n_in;
    logic [tcphft_pkg::CNT_W-1:0]     r_scan, n_scan;
    logic [tcphft_pkg::IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic                             r_cmp_vld, n_cmp_vld;
    logic [tcphft_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic [tcphft_pkg::CNT_W-1:0]     r_used, n_used;
    logic [tcphft_pkg::CNT_W-1:0]     r_done_cnt, n_done_cnt;
    logic                             r_out_vld, n_out_vld;
    tcphft_pkg::t_out_word            r_out, n_out;

    logic                             accept;
    logic [1:0]                       kind;
    logic [tcphft_pkg::KEY_W-1:0]     key_wdata;
    logic [tcphft_pkg::KEY_W-1:0]     key_rdata;
    logic                             key_we;
    logic                             stamp_we;
    logic [tcphft_pkg::IDX_W-1:0]     stamp_waddr;
    logic [tcphft_pkg::STAMP_W-1:0]   stamp_wdata;
    logic [tcphft_pkg::STAMP_W-1:0]   stamp_rdata;
    logic                             key_hit;

    assign accept    = i_start && !o_busy;
    assign kind      = tcphft_pkg::classify(r_in.tcp_flags);
    assign key_wdata = {r_in.src_addr, r_in.dst_addr, r_in.sport, r_in.dport};
    // The shared compare unit: one stored key against the packet's four-tuple per cycle.
    assign key_hit   = r_cmp_vld && (key_rdata == key_wdata);

    // Four-tuple of each entry: source, destination, source port, destination port.
    tcphft_ram #(
        .WIDTH(tcphft_pkg::KEY_W),
        .DEPTH(tcphft_pkg::ENTRIES)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(r_used[tcphft_pkg::IDX_W-1:0]),
        .i_wdata(key_wdata),
        .i_raddr(r_scan[tcphft_pkg::IDX_W-1:0]),
        .o_rdata(key_rdata)
    );

    // Completed mark in the top bit, start time below it. The ack time itself
    // is never stored, since the duration is formed from the live timestamp.
    tcphft_ram #(
        .WIDTH(tcphft_pkg::STAMP_W),
        .DEPTH(tcphft_pkg::ENTRIES)
    ) u_stamp_ram (
        .i_clk  (i_clk),
        .i_we   (stamp_we),
        .i_waddr(stamp_waddr),
        .i_wdata(stamp_wdata),
        .i_raddr(r_idx),
        .o_rdata(stamp_rdata)
    );

    always_comb begin
        tcphft_pkg::t_out_word res;
        logic                  was_done;
        logic [tcphft_pkg::TIME_W-1:0] start_t;

        n_state    = r_state;
        n_in       = r_in;
        n_scan     = r_scan;
        n_cmp_idx  = r_cmp_idx;
        n_cmp_vld  = r_cmp_vld;
        n_idx      = r_idx;
        n_used     = r_used;
        n_done_cnt = r_done_cnt;
        n_out_vld  = 1'b0;
        n_out      = r_out;
        key_we     = 1'b0;
        stamp_we   = 1'b0;
        stamp_waddr = r_idx;
        stamp_wdata = {1'b0, r_in.time_us};
        was_done   = stamp_rdata[tcphft_pkg::STAMP_W-1];
        start_t    = stamp_rdata[tcphft_pkg::TIME_W-1:0];

        res                   = '0;
        res.packet_kind       = kind;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_in = i_item;
                    if (i_item.ip_version == tcphft_pkg::IPV4_VERSION) begin
                        n_state   = S_SCAN;
                        n_scan    = '0;
                        n_cmp_vld = 1'b0;
                    end else begin
                        // Ignored word: every field but the counts reads zero.
                        res                   = '0;
                        res.status            = tcphft_pkg::ST_IGNORED;
                        res.entries_used      = 11'(r_used);
                        res.completed_entries = 11'(r_done_cnt);
                        n_out                 = res;
                        n_out_vld             = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (key_hit) begin
                    n_idx   = r_cmp_idx;
                    n_state = S_LOAD;
                end else if (r_scan < r_used) begin
                    n_cmp_idx = r_scan[tcphft_pkg::IDX_W-1:0];
                    n_cmp_vld = 1'b1;
                    n_scan    = r_scan + tcphft_pkg::CNT_W'(1);
                end else begin
                    n_state = S_IDLE;
                    if (r_used < tcphft_pkg::CNT_W'(tcphft_pkg::ENTRIES)) begin
                        // New entry: start time zero unless this is the SYN.
                        key_we      = 1'b1;
                        stamp_we    = 1'b1;
                        stamp_waddr = r_used[tcphft_pkg::IDX_W-1:0];
                        stamp_wdata = {kind == tcphft_pkg::KIND_ACK,
                                       (kind == tcphft_pkg::KIND_SYN) ? r_in.time_us
                                                                      : '0};
                        n_used      = r_used + tcphft_pkg::CNT_W'(1);
                        if (kind == tcphft_pkg::KIND_ACK) begin
                            n_done_cnt         = r_done_cnt + tcphft_pkg::CNT_W'(1);
                            res.just_completed = 1'b1;
                            res.duration_us    = r_in.time_us;
                        end
                        res.status      = tcphft_pkg::ST_CREATED;
                        res.entry_index = 10'(r_used[tcphft_pkg::IDX_W-1:0]);
                    end else begin
                        res.status = tcphft_pkg::ST_FULL;
                    end
                    res.entries_used      = 11'(n_used);
                    res.completed_entries = 11'(n_done_cnt);
                    n_out                 = res;
                    n_out_vld             = 1'b1;
                end
            end
            S_LOAD: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_IDLE;
                if (kind == tcphft_pkg::KIND_SYN) begin
                    stamp_we    = 1'b1;
                    stamp_wdata = {was_done, r_in.time_us};
                end else if (kind == tcphft_pkg::KIND_ACK) begin
                    stamp_we        = 1'b1;
                    stamp_wdata     = {1'b1, start_t};
                    res.duration_us = r_in.time_us - start_t;
                    if (!was_done) begin
                        n_done_cnt         = r_done_cnt + tcphft_pkg::CNT_W'(1);
                        res.just_completed = 1'b1;
                    end
                end
                res.status            = tcphft_pkg::ST_MATCHED;
                res.entry_index       = 10'(r_idx);
                res.entries_used      = 11'(n_used);
                res.completed_entries = 11'(n_done_cnt);
                n_out                 = res;
                n_out_vld             = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmp_vld  <= 1'b0;
            r_used     <= '0;
            r_done_cnt <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_vld  <= n_cmp_vld;
            r_used     <= n_used;
            r_done_cnt <= n_done_cnt;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_scan    <= n_scan;
        r_cmp_idx <= n_cmp_idx;
        r_idx     <= n_idx;
        r_out     <= n_out;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_out_vld;
    assign o_result = r_out;

    // A result only appears once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while sequencer busy");

    // The allocation count never passes the table size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= tcphft_pkg::CNT_W'(tcphft_pkg::ENTRIES))
        else $error("entry count beyond table size");

    // Only allocated entries can be completed.
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_cnt <= r_used)
        else $error("completed count above entry count");

    // Every accepted word either starts a lookup or yields its result at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_busy || o_done))
        else $error("accepted word dropped");

    // The scan never compares at or past the allocation count.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan <= r_used))
        else $error("scan pointer past used entries");

endmodule

[verif/tcp_handshake_flow_table_unit_checker.sv]
// Checker for the TCP handshake flow table: tracks flows, predicts each result word and compares.
`timescale 1ns / 1ps
module tcp_handshake_flow_table_unit_checker
    import tcphft_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_word  i_item,
    input  logic      i_done,
    input  t_out_word i_result,
    output int        o_mismatches,
    output int        o_outstanding
);

    // Shadow copy of the flow table. Only slots below flows_in_use are ever read.
    logic [31:0]       key_src    [ENTRIES];
    logic [31:0]       key_dst    [ENTRIES];
    logic [31:0]       key_ports  [ENTRIES];
    logic [TIME_W-1:0] syn_stamp  [ENTRIES];
    logic              flow_done  [ENTRIES];
    int                flows_in_use;
    int                flows_completed;

    t_out_word expected_words[$];
    int        mismatch_count = 0;

    // Applies one packet word to the shadow table and returns the result word it should give.
    function automatic t_out_word track_packet(input t_in_word w);
        t_out_word   r;
        logic [31:0] ports;
        logic        syn_bit;
        logic        ack_bit;
        int          slot;
        int          k;
        r       = '0;
        ports   = {w.sport, w.dport};
        syn_bit = w.tcp_flags[FLAG_SYN_BIT];
        ack_bit = w.tcp_flags[FLAG_ACK_BIT];
        slot    = -1;
        if (w.ip_version == IPV4_VERSION) begin
            if (syn_bit) begin
                r.packet_kind = ack_bit ? KIND_SYNACK : KIND_SYN;
            end else begin
                r.packet_kind = ack_bit ? KIND_ACK : KIND_OTHER;
            end
            for (k = 0; k < flows_in_use; k++) begin
                if (slot < 0 && key_src[k] == w.src_addr && key_dst[k] == w.dst_addr
                        && key_ports[k] == ports) begin
                    slot = k;
                end
            end
            if (slot >= 0) begin
                r.status = ST_MATCHED;
            end else if (flows_in_use < ENTRIES) begin
                slot            = flows_in_use;
                key_src[slot]   = w.src_addr;
                key_dst[slot]   = w.dst_addr;
                key_ports[slot] = ports;
                syn_stamp[slot] = '0;
                flow_done[slot] = 1'b0;
                flows_in_use++;
                r.status = ST_CREATED;
            end else begin
                r.status = ST_FULL;
            end
            if (slot >= 0) begin
                r.entry_index = 10'(slot);
                if (r.packet_kind == KIND_SYN) begin
                    syn_stamp[slot] = w.time_us;
                end else if (r.packet_kind == KIND_ACK) begin
                    if (!flow_done[slot]) begin
                        flow_done[slot] = 1'b1;
                        flows_completed++;
                        r.just_completed = 1'b1;
                    end
                    r.duration_us = w.time_us - syn_stamp[slot];
                end
            end
        end
        r.entries_used      = 11'(flows_in_use);
        r.completed_entries = 11'(flows_completed);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (!i_rst_n) begin
            flows_in_use    = 0;
            flows_completed = 0;
            expected_words.delete();
        end else begin
            // Results are compared before a word accepted at the same edge is predicted.
            if (i_done) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_result);
                end else begin
                    want = expected_words.pop_front();
                    check_field("status", want.status, i_result.status);
                    check_field("entry_index", want.entry_index, i_result.entry_index);
                    check_field("packet_kind", want.packet_kind, i_result.packet_kind);
                    check_field("just_completed", want.just_completed,
                                i_result.just_completed);
                    check_field("duration_us", $unsigned(want.duration_us),
                                $unsigned(i_result.duration_us));
                    check_field("entries_used", want.entries_used, i_result.entries_used);
                    check_field("completed_entries", want.completed_entries,
                                i_result.completed_entries);
                end
            end
            if (i_start && !i_busy) begin
                expected_words.push_back(track_packet(i_item));
            end
        end
        o_mismatches  = mismatch_count;
        o_outstanding = expected_words.size();
    end

endmodule

[verif/tcp_handshake_flow_table_unit_tb.sv]
// Testbench top for the TCP handshake flow table: packet stimulus, checker hookup and verdict.
`timescale 1ns / 1ps
module tcp_handshake_flow_table_unit_tb;
    import tcphft_pkg::*;

    // Number of IPv4 words in the random part; non-IPv4 noise does not count.
    localparam int RANDOM_WORDS = 400;
    // A full-table lookup scans all ENTRIES entries, so the tail watch is sized above that.
    localparam int DRAIN_CYCLES = ENTRIES + 64;
    localparam int POOL_DEPTH   = 48;

    // One direction of a TCP connection: the four-tuple the table keys on.
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_flow;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_in_word  i_item  = '0;
    logic      o_busy;
    logic      o_done;
    t_out_word o_result;

    int          mismatches;
    int          outstanding;
    int          ipv4_sent = 0;
    logic        idle_on   = 1'b1;
    t_flow       flow_pool[$];

    tcp_handshake_flow_table_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    tcp_handshake_flow_table_unit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_item        (i_item),
        .i_done        (o_done),
        .i_result      (o_result),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: a timeout that ends the run as a failure.
    initial begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

    // Presents a word at the falling edge and holds it until a rising edge sees busy low.
    // Start stays high on return, so a following word goes out back to back.
    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        i_start <= 1'b1;
        i_item  <= w;
        do @(posedge i_clk); while (o_busy);
        if (w.ip_version == IPV4_VERSION) begin
            ipv4_sent++;
        end
    endtask

    task automatic pause(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
    endtask

    task automatic maybe_pause();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            pause($urandom_range(1, 11));
        end
    endtask

    // Drops start and waits at falling edges until every result is back.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end while (outstanding != 0);
    endtask

    function automatic t_in_word packet(input t_flow f, input logic [7:0] flags,
                                        input logic [TIME_W-1:0] stamp);
        t_in_word w;
        w.ip_version = IPV4_VERSION;
        w.src_addr   = f.src_addr;
        w.dst_addr   = f.dst_addr;
        w.sport      = f.sport;
        w.dport      = f.dport;
        w.tcp_flags  = flags;
        w.time_us    = stamp;
        return w;
    endfunction

    // The answering direction of a connection has its own entry in the table.
    function automatic t_flow reversed(input t_flow f);
        t_flow r;
        r.src_addr = f.dst_addr;
        r.dst_addr = f.src_addr;
        r.sport    = f.dport;
        r.dport    = f.sport;
        return r;
    endfunction

    function automatic t_flow random_flow();
        t_flow f;
        f.src_addr = $urandom;
        f.dst_addr = $urandom;
        f.sport    = 16'($urandom_range(0, 65535));
        f.dport    = 16'($urandom_range(0, 65535));
        return f;
    endfunction

    function automatic logic [TIME_W-1:0] random_stamp();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    // Random flag byte with the SYN and ACK bits forced; the other bits are noise.
    function automatic logic [7:0] flags_with(input logic syn, input logic ack);
        logic [7:0] f;
        f = 8'($urandom_range(0, 255));
        f[FLAG_SYN_BIT] = syn;
        f[FLAG_ACK_BIT] = ack;
        return f;
    endfunction

    // A word with any version other than IPv4 and random content; the block ignores it.
    function automatic t_in_word noise_word();
        t_in_word w;
        logic [3:0] v;
        w = packet(random_flow(), 8'($urandom_range(0, 255)), random_stamp());
        v = 4'($urandom_range(0, 14));
        if (v >= IPV4_VERSION) begin
            v = v + 4'd1;
        end
        w.ip_version = v;
        return w;
    endfunction

    // One three-way handshake on a new or reused connection. Steps are dropped now and
    // then, and an ACK is sometimes repeated, so broken sequences show up as well.
    task automatic handshake();
        t_flow             client;
        logic [TIME_W-1:0] stamp;
        if (flow_pool.size() == 0 || $urandom_range(0, 2) == 0) begin
            client = random_flow();
            if (flow_pool.size() < POOL_DEPTH) begin
                flow_pool.push_back(client);
            end else begin
                flow_pool[$urandom_range(0, POOL_DEPTH - 1)] = client;
            end
        end else begin
            client = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
        end
        stamp = ($urandom_range(0, 9) == 0) ? random_stamp() : {16'h0, $urandom};
        if ($urandom_range(0, 9) != 0) begin
            maybe_pause();
            send_word(packet(client, flags_with(1'b1, 1'b0), stamp));
        end
        stamp = stamp + $urandom_range(1, 3000);
        if ($urandom_range(0, 9) != 0) begin
            maybe_pause();
            send_word(packet(reversed(client), flags_with(1'b1, 1'b1), stamp));
        end
        // Occasionally the ACK time is unrelated, so the duration goes negative or wraps.
        if ($urandom_range(0, 9) == 0) begin
            stamp = random_stamp();
        end else begin
            stamp = stamp + $urandom_range(0, 3000);
        end
        if ($urandom_range(0, 9) != 0) begin
            maybe_pause();
            send_word(packet(client, flags_with(1'b0, 1'b1), stamp));
        end
        if ($urandom_range(0, 7) == 0) begin
            maybe_pause();
            send_word(packet(client, flags_with(1'b0, 1'b1), stamp + $urandom_range(0, 99)));
        end
    endtask

    initial begin : stimulus
        t_flow    zero_flow;
        t_flow    ones_flow;
        t_flow    mid_flow;
        t_flow    swapped_ports;
        t_flow    stray;
        t_in_word w;
        int       random_base;
        int       choice;

        // Synchronous reset, held low from time zero and released at a falling edge.
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        zero_flow     = '0;
        ones_flow     = '1;
        mid_flow      = '{src_addr: 32'h8000_0001, dst_addr: 32'h7FFF_FFFE,
                          sport: 16'h8000, dport: 16'h7FFF};
        swapped_ports = mid_flow;
        swapped_ports.sport = mid_flow.dport;
        swapped_ports.dport = mid_flow.sport;

        // Directed part. Non-IPv4 words at both ends of the version range, and one in between.
        send_word('0);
        send_word('1);
        w = noise_word();
        w.ip_version = 4'd6;
        send_word(w);
        // All-zero tuple: created with an other-flags word, then SYN at the latest time
        // and an ACK at time zero, so the duration wraps around to one.
        send_word(packet(zero_flow, 8'h00, '0));
        send_word(packet(zero_flow, 8'h02, '1));
        send_word(packet(zero_flow, 8'h10, '0));
        // ACK to a connection that is already complete: the start time stays, no new completion.
        send_word(packet(zero_flow, 8'hFD, 48'd5));
        // All-ones tuple: a SYN-ACK creates it; an ACK arrives before any SYN.
        send_word(packet(ones_flow, 8'hFF, '1));
        send_word(packet(ones_flow, 8'h10, 48'h8000_0000_0000));
        // Start time at the signed maximum, then ACKs below and above it.
        send_word(packet(mid_flow, 8'hEF, 48'h7FFF_FFFF_FFFF));
        send_word(packet(mid_flow, 8'h10, '0));
        send_word(packet(mid_flow, 8'h10, '1));
        send_word(packet(mid_flow, 8'hED, 48'h1234_5678_9ABC));
        // Reversed direction and swapped ports are distinct keys.
        send_word(packet(reversed(mid_flow), 8'h12, 48'h0000_0000_0100));
        send_word(packet(swapped_ports, 8'h02, 48'h0000_0000_0200));
        // A non-IPv4 ACK on a known tuple must leave that entry alone.
        w = packet(zero_flow, 8'h10, 48'hABCD);
        w.ip_version = 4'd5;
        send_word(w);
        send_word(packet(zero_flow, 8'hEC, 48'h7));

        // Random part: mostly handshakes with random content, the rest stray packets,
        // non-IPv4 noise and one-off tuples. Idling switches on and off in stretches.
        random_base = ipv4_sent;
        while (ipv4_sent - random_base < RANDOM_WORDS) begin
            if ($urandom_range(0, 19) == 0) begin
                idle_on = ~idle_on;
            end
            choice = $urandom_range(0, 99);
            maybe_pause();
            if (choice < 65) begin
                handshake();
            end else if (choice < 82 && flow_pool.size() != 0) begin
                stray = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
                if ($urandom_range(0, 1) == 0) begin
                    stray = reversed(stray);
                end
                send_word(packet(stray, 8'($urandom_range(0, 255)), random_stamp()));
            end else if (choice < 94) begin
                send_word(noise_word());
            end else begin
                send_word(packet(random_flow(), 8'($urandom_range(0, 255)), random_stamp()));
            end
        end

        // Last part, no idling: handshakes and words back to back, a hit on entry zero,
        // fresh tuples as SYN-ACK, ACK and other words, and noise.
        idle_on = 1'b0;
        repeat (6) handshake();
        send_word(packet(zero_flow, 8'h02, random_stamp()));
        send_word(packet(random_flow(), flags_with(1'b1, 1'b1), random_stamp()));
        send_word(packet(random_flow(), flags_with(1'b0, 1'b1), random_stamp()));
        send_word(packet(random_flow(), flags_with(1'b0, 1'b0), random_stamp()));
        send_word(noise_word());
        send_word(packet(mid_flow, 8'h10, random_stamp()));
        wait_drained();

        // Watch a while longer for stray result strobes.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
